// ===== src/bevg_pkg.sv =====
// ----------------------------------------------------------------------------
// bevg_pkg
// Shared constants and types for the button event grammar block.
// ----------------------------------------------------------------------------
package bevg_pkg;

	localparam int NUM_KEYS = 12;
	localparam int KIDX_W   = (NUM_KEYS > 1) ? $clog2(NUM_KEYS) : 1;
	localparam int KEY_W    = 4;
	localparam int KIND_W   = 3;
	localparam int POS_W    = 3;
	localparam int SEQ_W    = 32;
	localparam int TIME_W   = 32;
	localparam int TICK_W   = 16;
	localparam int ADDR_W   = 5;
	localparam int DATA_W   = 32;

	// event kinds
	localparam logic [KIND_W-1:0] EV_PRESS    = 3'd0;
	localparam logic [KIND_W-1:0] EV_SHORT    = 3'd1;
	localparam logic [KIND_W-1:0] EV_RELEASE  = 3'd2;
	localparam logic [KIND_W-1:0] EV_LONG     = 3'd3;
	localparam logic [KIND_W-1:0] EV_REPEAT   = 3'd4;
	localparam logic [KIND_W-1:0] EV_POSITION = 3'd5;

	// input actions
	localparam logic ACT_KEY  = 1'b0;
	localparam logic ACT_TICK = 1'b1;

	// register indexes (word address)
	localparam logic [2:0] REG_LONG_PRESS = 3'd0;
	localparam logic [2:0] REG_REPEAT     = 3'd1;
	localparam logic [2:0] REG_STARTUP    = 3'd2;
	localparam logic [2:0] REG_SEL_FIRST  = 3'd3;
	localparam logic [2:0] REG_SEL_LAST   = 3'd4;
	localparam logic [2:0] REG_ABSENT     = 3'd5;

	localparam logic [POS_W-1:0] POS_UNKNOWN = 3'd7;
	localparam logic [POS_W-1:0] POS_MAX     = 3'd6;

	typedef struct packed {
		logic [KEY_W-1:0]  key;
		logic [KIND_W-1:0] kind;
		logic [SEQ_W-1:0]  seq;
		logic [POS_W-1:0]  pos;
	} ev_t;

endpackage

// ===== src/bevg_in_if.sv =====
// ----------------------------------------------------------------------------
// bevg_in_if
// Input channel: key level changes and time ticks.
// ----------------------------------------------------------------------------
interface bevg_in_if;
	logic       valid;
	logic       ready;
	logic       action;
	logic [3:0] key_index;
	logic       key_level;

	modport source (output valid, output action, output key_index, output key_level,
		input ready);
	modport sink (input valid, input action, input key_index, input key_level,
		output ready);
endinterface

// ===== src/bevg_out_if.sv =====
// ----------------------------------------------------------------------------
// bevg_out_if
// Output channel: key and selector events.
// ----------------------------------------------------------------------------
interface bevg_out_if;
	logic        valid;
	logic        ready;
	logic [3:0]  event_key;
	logic [2:0]  event_kind;
	logic [31:0] event_seq;
	logic [2:0]  selector_position;
	logic        last;

	modport source (output valid, output event_key, output event_kind,
		output event_seq, output selector_position, output last, input ready);
	modport sink (input valid, input event_key, input event_kind,
		input event_seq, input selector_position, input last, output ready);
endinterface

// ===== src/button_event_grammar_top.sv =====
// ----------------------------------------------------------------------------
// button_event_grammar_top
// Turns key level changes and time ticks into press/short/release/long/
// repeat events and selector position events.
// ----------------------------------------------------------------------------
//
//  channel   dir  protocol         payload
//  -------   ---  --------------   -----------------------------------------
//  key_in    in   valid/ready      action, key_index, key_level
//  evt_out   out  valid/ready      event_key, event_kind, event_seq,
//                                  selector_position, last
//  apb       in   APB, 5b address  six config registers at 4*i
//
//  A key change runs the select, key and (on a release) release states; an
//  ignored key goes straight to done. A tick scans one key per cycle, unless
//  evt_out stalls, through the single elapsed-time subtract/compare unit.
//  key_in.ready is high only while the sequencer idles. arst_n clears all key
//  state, counters and the config registers to their defaults. Each event
//  waits in a pending register until the next event or the end of the item
//  decides its last bit; a stalled evt_out freezes the sequencer while both
//  that register and the output register are full.
// ----------------------------------------------------------------------------
module button_event_grammar_top (
	input  logic                           clk,
	input  logic                           arst_n,
	bevg_in_if.sink                        key_in,
	bevg_out_if.source                     evt_out,
	input  logic                           psel,
	input  logic                           penable,
	input  logic                           pwrite,
	input  logic [bevg_pkg::ADDR_W-1:0]    paddr,
	input  logic [bevg_pkg::DATA_W-1:0]    pwdata,
	output logic [bevg_pkg::DATA_W-1:0]    prdata,
	output logic                           pready
);

	// sequencer states
	localparam logic [2:0] S_IDLE   = 3'd0;
	localparam logic [2:0] S_KSEL   = 3'd1;
	localparam logic [2:0] S_KKEY   = 3'd2;
	localparam logic [2:0] S_KREL   = 3'd3;
	localparam logic [2:0] S_TSTART = 3'd4;
	localparam logic [2:0] S_SCAN   = 3'd5;
	localparam logic [2:0] S_DONE   = 3'd6;

	localparam logic [2:0] REG_LONG_PRESS_C = bevg_pkg::REG_LONG_PRESS;
	localparam logic [2:0] REG_REPEAT_C     = bevg_pkg::REG_REPEAT;
	localparam logic [2:0] REG_STARTUP_C    = bevg_pkg::REG_STARTUP;
	localparam logic [2:0] REG_SEL_FIRST_C  = bevg_pkg::REG_SEL_FIRST;
	localparam logic [2:0] REG_SEL_LAST_C   = bevg_pkg::REG_SEL_LAST;
	localparam logic [2:0] REG_ABSENT_C     = bevg_pkg::REG_ABSENT;

	// ---------------- config registers ----------------
	logic [bevg_pkg::TICK_W-1:0] long_press_q, repeat_q, startup_q, absent_q;
	logic [bevg_pkg::KEY_W-1:0]  sel_first_q, sel_last_q;
	logic                        cfg_wr;
	logic [2:0]                  cfg_idx;

	assign pready  = 1'b1;
	assign cfg_idx = paddr[4:2];
	assign cfg_wr  = psel && penable && pwrite;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			long_press_q <= 16'd300;
			repeat_q     <= 16'd150;
			startup_q    <= 16'd1500;
			sel_first_q  <= 4'd7;
			sel_last_q   <= 4'd11;
			absent_q     <= 16'd12;
		end else if (cfg_wr) begin
			case (cfg_idx)
				REG_LONG_PRESS_C: long_press_q <= pwdata[15:0];
				REG_REPEAT_C:     repeat_q     <= pwdata[15:0];
				REG_STARTUP_C:    startup_q    <= pwdata[15:0];
				REG_SEL_FIRST_C:  sel_first_q  <= pwdata[3:0];
				REG_SEL_LAST_C:   sel_last_q   <= pwdata[3:0];
				REG_ABSENT_C:     absent_q     <= pwdata[15:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		prdata = '0;
		case (cfg_idx)
			REG_LONG_PRESS_C: prdata = {16'd0, long_press_q};
			REG_REPEAT_C:     prdata = {16'd0, repeat_q};
			REG_STARTUP_C:    prdata = {16'd0, startup_q};
			REG_SEL_FIRST_C:  prdata = {28'd0, sel_first_q};
			REG_SEL_LAST_C:   prdata = {28'd0, sel_last_q};
			REG_ABSENT_C:     prdata = {16'd0, absent_q};
			default:          prdata = '0;
		endcase
	end

	// ---------------- key state ----------------
	logic                          held_q   [bevg_pkg::NUM_KEYS];
	logic                          long_q   [bevg_pkg::NUM_KEYS];
	logic [bevg_pkg::TIME_W-1:0]   press_t_q[bevg_pkg::NUM_KEYS];
	logic [bevg_pkg::TIME_W-1:0]   rep_t_q  [bevg_pkg::NUM_KEYS];
	logic [bevg_pkg::SEQ_W-1:0]    kseq_q   [bevg_pkg::NUM_KEYS];
	logic [bevg_pkg::SEQ_W-1:0]    press_cnt_q;
	logic [bevg_pkg::TIME_W-1:0]   time_q;
	logic                          startup_done_q;
	logic [bevg_pkg::POS_W-1:0]    position_q;

	// sequencer and latched input
	logic [2:0]                    state_q;
	logic [bevg_pkg::KIDX_W-1:0]   scan_q;
	logic [bevg_pkg::KEY_W-1:0]    key_q;
	logic                          level_q;

	// pending event and output register
	bevg_pkg::ev_t                 pend_q, out_q;
	logic                          pend_v_q, out_v_q, out_last_q;

	// ---------------- per-step decode ----------------
	logic [bevg_pkg::KIDX_W-1:0]   idx;
	logic                          key_present, scan_present;
	logic                          sel_hit;
	logic [bevg_pkg::KEY_W-1:0]    sel_off;
	logic [bevg_pkg::POS_W-1:0]    sel_pos;
	logic [bevg_pkg::SEQ_W-1:0]    cnt_inc;

	assign idx     = (state_q == S_SCAN) ? scan_q : key_q[bevg_pkg::KIDX_W-1:0];
	assign key_present = ({1'b0, key_q} < 5'(bevg_pkg::NUM_KEYS)) && !absent_q[key_q];
	assign scan_present = !absent_q[bevg_pkg::KEY_W'(scan_q)];
	assign sel_hit = level_q && (key_q >= sel_first_q) && (key_q <= sel_last_q);
	assign sel_off = key_q - sel_first_q;
	assign sel_pos = (sel_off > 4'(bevg_pkg::POS_MAX)) ? bevg_pkg::POS_MAX
		: sel_off[bevg_pkg::POS_W-1:0];
	assign cnt_inc = press_cnt_q + 32'd1;

	// shared elapsed-time unit: (time - base) >= threshold
	logic [bevg_pkg::TIME_W-1:0]   u_base, u_thr, u_diff;
	logic                          u_ge;

	always_comb begin
		if (state_q == S_TSTART) begin
			u_base = '0;
			u_thr  = {16'd0, startup_q};
		end else if (long_q[idx]) begin
			u_base = rep_t_q[idx];
			u_thr  = {16'd0, repeat_q};
		end else begin
			u_base = press_t_q[idx];
			u_thr  = {16'd0, long_press_q};
		end
	end

	assign u_diff = time_q - u_base;
	assign u_ge   = (u_diff >= u_thr);

	logic scan_fire;
	assign scan_fire = held_q[idx] && scan_present && u_ge;

	// event produced this step
	logic          emit_v;
	bevg_pkg::ev_t emit_ev;

	always_comb begin
		emit_v  = 1'b0;
		emit_ev = '{key: key_q, kind: bevg_pkg::EV_PRESS, seq: kseq_q[idx], pos: position_q};
		case (state_q)
			S_KSEL: begin
				emit_v  = key_present && sel_hit && (sel_pos != position_q);
				emit_ev = '{key: sel_first_q + bevg_pkg::KEY_W'(sel_pos),
					kind: bevg_pkg::EV_POSITION, seq: '0, pos: sel_pos};
			end
			S_KKEY: begin
				if (level_q && !held_q[idx]) begin
					emit_v      = 1'b1;
					emit_ev.seq = cnt_inc;
				end else if (!level_q && held_q[idx] && !long_q[idx]) begin
					emit_v       = 1'b1;
					emit_ev.kind = bevg_pkg::EV_SHORT;
				end
			end
			S_KREL: begin
				emit_v       = 1'b1;
				emit_ev.kind = bevg_pkg::EV_RELEASE;
			end
			S_TSTART: begin
				emit_v  = !startup_done_q && u_ge && (position_q != '0);
				emit_ev = '{key: sel_first_q, kind: bevg_pkg::EV_POSITION,
					seq: '0, pos: '0};
			end
			S_SCAN: begin
				emit_v       = scan_fire;
				emit_ev.key  = bevg_pkg::KEY_W'(scan_q);
				emit_ev.kind = long_q[idx] ? bevg_pkg::EV_REPEAT : bevg_pkg::EV_LONG;
			end
			default: emit_v = 1'b0;
		endcase
	end

	// a step may go ahead when the pending slot can be drained if needed
	logic out_free, step_ok, push, accept;
	assign out_free = !out_v_q || evt_out.ready;
	assign step_ok  = !pend_v_q || out_free;
	assign push     = step_ok && pend_v_q && (emit_v || state_q == S_DONE);
	assign accept   = key_in.valid && key_in.ready;

	assign key_in.ready = (state_q == S_IDLE);

	// ---------------- sequencer and key state ----------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= S_IDLE;
			scan_q         <= '0;
			press_cnt_q    <= '0;
			time_q         <= '0;
			startup_done_q <= 1'b0;
			position_q     <= bevg_pkg::POS_UNKNOWN;
			pend_v_q       <= 1'b0;
			out_v_q        <= 1'b0;
			for (int i = 0; i < bevg_pkg::NUM_KEYS; i++) begin
				held_q[i]    <= 1'b0;
				long_q[i]    <= 1'b0;
				press_t_q[i] <= '0;
				rep_t_q[i]   <= '0;
				kseq_q[i]    <= '0;
			end
		end else begin
			if (push)
				out_v_q <= 1'b1;
			else if (evt_out.ready)
				out_v_q <= 1'b0;

			if (step_ok && emit_v)
				pend_v_q <= 1'b1;
			else if (step_ok && state_q == S_DONE)
				pend_v_q <= 1'b0;

			case (state_q)
				S_IDLE: begin
					if (accept) begin
						if (key_in.action == bevg_pkg::ACT_TICK) begin
							time_q  <= time_q + 32'd1;
							state_q <= S_TSTART;
						end else begin
							state_q <= S_KSEL;
						end
					end
				end
				S_KSEL: begin
					if (step_ok) begin
						if (!key_present) begin
							state_q <= S_DONE;
						end else begin
							if (sel_hit) begin
								startup_done_q <= 1'b1;
								position_q     <= sel_pos;
							end
							state_q <= S_KKEY;
						end
					end
				end
				S_KKEY: begin
					if (step_ok) begin
						if (level_q && !held_q[idx]) begin
							held_q[idx]    <= 1'b1;
							long_q[idx]    <= 1'b0;
							press_t_q[idx] <= time_q;
							rep_t_q[idx]   <= time_q;
							kseq_q[idx]    <= cnt_inc;
							press_cnt_q    <= cnt_inc;
							state_q        <= S_DONE;
						end else if (!level_q && held_q[idx]) begin
							held_q[idx] <= 1'b0;
							state_q     <= S_KREL;
						end else begin
							state_q <= S_DONE;
						end
					end
				end
				S_KREL: begin
					if (step_ok)
						state_q <= S_DONE;
				end
				S_TSTART: begin
					if (step_ok) begin
						if (!startup_done_q && u_ge) begin
							startup_done_q <= 1'b1;
							position_q     <= '0;
						end
						scan_q  <= '0;
						state_q <= S_SCAN;
					end
				end
				S_SCAN: begin
					if (step_ok) begin
						if (scan_fire) begin
							long_q[idx]  <= 1'b1;
							rep_t_q[idx] <= time_q;
						end
						if (scan_q == bevg_pkg::KIDX_W'(bevg_pkg::NUM_KEYS - 1))
							state_q <= S_DONE;
						else
							scan_q <= scan_q + 1'b1;
					end
				end
				S_DONE: begin
					if (step_ok)
						state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// ---------------- payload registers ----------------
	always_ff @(posedge clk) begin
		if (accept) begin
			key_q   <= key_in.key_index;
			level_q <= key_in.key_level;
		end
		if (step_ok && emit_v)
			pend_q <= emit_ev;
		if (push) begin
			out_q      <= pend_q;
			out_last_q <= (state_q == S_DONE);
		end
	end

	assign evt_out.valid             = out_v_q;
	assign evt_out.event_key         = out_q.key;
	assign evt_out.event_kind        = out_q.kind;
	assign evt_out.event_seq         = out_q.seq;
	assign evt_out.selector_position = out_q.pos;
	assign evt_out.last              = out_last_q;

endmodule

// ===== dv/bevg_event_checker.sv =====
// ----------------------------------------------------------------------------
// bevg_event_checker
// Watches the key and event channels and the register port. It keeps its own
// model of the key state and settings, works out the events that each
// accepted key change or tick must produce, and compares every event
// transfer in order.
// ----------------------------------------------------------------------------
module bevg_event_checker
	import bevg_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	bevg_in_if                key_mon,
	bevg_out_if               evt_mon,
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic              pready,
	input  logic [ADDR_W-1:0] paddr,
	input  logic [DATA_W-1:0] pwdata,
	output int                fail_count,
	output int                pending
);

	typedef struct packed {
		ev_t  ev;
		logic last;
	} key_event_t;

	// settings as the block should hold them
	logic [15:0] long_ticks;
	logic [15:0] repeat_period;
	logic [15:0] boot_timeout;
	logic [3:0]  sel_lo;
	logic [3:0]  sel_hi;
	logic [15:0] absent_mask;

	// per-key and global model state
	logic [NUM_KEYS-1:0] key_down;
	logic [NUM_KEYS-1:0] long_fired;
	logic [31:0]         down_since [NUM_KEYS];
	logic [31:0]         last_fire  [NUM_KEYS];
	logic [31:0]         key_seq    [NUM_KEYS];
	logic [31:0]         seq_counter;
	logic [31:0]         now_ticks;
	logic                boot_done;
	logic [POS_W-1:0]    cur_pos;

	key_event_t events_due [$];
	key_event_t step_events [$];

	function automatic logic key_exists(input logic [3:0] k);
		return (k < NUM_KEYS) && (absent_mask[k] == 1'b0);
	endfunction

	function automatic void note_event(input logic [3:0] k, input logic [KIND_W-1:0] kind,
		input logic [31:0] seq);
		key_event_t e;
		e.ev.key  = k;
		e.ev.kind = kind;
		e.ev.seq  = seq;
		e.ev.pos  = cur_pos;
		e.last    = 1'b0;
		step_events.push_back(e);
	endfunction

	function automatic void move_selector(input logic [POS_W-1:0] pos);
		if (pos != cur_pos) begin
			cur_pos = pos;
			note_event(sel_lo + {1'b0, pos}, EV_POSITION, '0);
		end
	endfunction

	function automatic void log_mismatch(input string why, input key_event_t want,
		input key_event_t got);
		fail_count++;
		if (fail_count <= 10)
			$display("%0t: %s: expected key %0d kind %0d seq %0d pos %0d last %0b,",
				$realtime, why, want.ev.key, want.ev.kind, want.ev.seq, want.ev.pos, want.last,
				" got key %0d kind %0d seq %0d pos %0d last %0b",
				got.ev.key, got.ev.kind, got.ev.seq, got.ev.pos, got.last);
	endfunction

	always @(posedge clk or negedge arst_n) begin
		key_event_t       got;
		key_event_t       want;
		logic [3:0]       k;
		logic [3:0]       off;
		logic [31:0]      dt;
		if (!arst_n) begin
			long_ticks    = 16'd300;
			repeat_period = 16'd150;
			boot_timeout  = 16'd1500;
			sel_lo        = 4'd7;
			sel_hi        = 4'd11;
			absent_mask   = 16'd12;
			key_down      = '0;
			long_fired    = '0;
			for (int i = 0; i < NUM_KEYS; i++) begin
				down_since[i] = '0;
				last_fire[i]  = '0;
				key_seq[i]    = '0;
			end
			seq_counter = '0;
			now_ticks   = '0;
			boot_done   = 1'b0;
			cur_pos     = POS_UNKNOWN;
			events_due.delete();
			step_events.delete();
			fail_count = 0;
			pending    = 0;
		end else begin
			if (psel && penable && pwrite && pready) begin
				case (paddr[4:2])
					REG_LONG_PRESS: long_ticks    = pwdata[15:0];
					REG_REPEAT:     repeat_period = pwdata[15:0];
					REG_STARTUP:    boot_timeout  = pwdata[15:0];
					REG_SEL_FIRST:  sel_lo        = pwdata[3:0];
					REG_SEL_LAST:   sel_hi        = pwdata[3:0];
					REG_ABSENT:     absent_mask   = pwdata[15:0];
					default: ;
				endcase
			end

			if (key_mon.valid && key_mon.ready) begin
				k = key_mon.key_index;
				if (key_mon.action == ACT_KEY) begin
					if (key_exists(k)) begin
						if (key_mon.key_level && k >= sel_lo && k <= sel_hi) begin
							off = k - sel_lo;
							boot_done = 1'b1;
							move_selector((off > 4'd6) ? POS_MAX : off[POS_W-1:0]);
						end
						if (key_mon.key_level && !key_down[k]) begin
							key_down[k]   = 1'b1;
							down_since[k] = now_ticks;
							long_fired[k] = 1'b0;
							last_fire[k]  = now_ticks;
							seq_counter   = seq_counter + 32'd1;
							key_seq[k]    = seq_counter;
							note_event(k, EV_PRESS, key_seq[k]);
						end else if (!key_mon.key_level && key_down[k]) begin
							key_down[k] = 1'b0;
							if (!long_fired[k])
								note_event(k, EV_SHORT, key_seq[k]);
							note_event(k, EV_RELEASE, key_seq[k]);
						end
					end
				end else begin
					now_ticks = now_ticks + 32'd1;
					if (!boot_done && now_ticks >= {16'd0, boot_timeout}) begin
						boot_done = 1'b1;
						move_selector('0);
					end
					for (int i = 0; i < NUM_KEYS; i++) begin
						if (!key_down[i] || !key_exists(4'(i)))
							continue;
						if (!long_fired[i]) begin
							dt = now_ticks - down_since[i];
							if (dt >= {16'd0, long_ticks}) begin
								long_fired[i] = 1'b1;
								last_fire[i]  = now_ticks;
								note_event(4'(i), EV_LONG, key_seq[i]);
							end
						end else begin
							dt = now_ticks - last_fire[i];
							if (dt >= {16'd0, repeat_period}) begin
								last_fire[i] = now_ticks;
								note_event(4'(i), EV_REPEAT, key_seq[i]);
							end
						end
					end
				end
				if (step_events.size() > 0) begin
					step_events[step_events.size() - 1].last = 1'b1;
					foreach (step_events[j])
						events_due.push_back(step_events[j]);
					step_events.delete();
				end
			end

			if (evt_mon.valid && evt_mon.ready) begin
				got.ev.key  = evt_mon.event_key;
				got.ev.kind = evt_mon.event_kind;
				got.ev.seq  = evt_mon.event_seq;
				got.ev.pos  = evt_mon.selector_position;
				got.last    = evt_mon.last;
				if (events_due.size() == 0) begin
					log_mismatch("event with nothing outstanding", '0, got);
				end else begin
					want = events_due.pop_front();
					if (got !== want)
						log_mismatch("event mismatch", want, got);
				end
			end
			pending = events_due.size();
		end
	end

endmodule

// ===== dv/button_event_grammar_top_test.sv =====
// ----------------------------------------------------------------------------
// button_event_grammar_top_test
// Drives key level changes and ticks into the button event block under
// random source gaps and sink stalls, across several register settings.
// A checker beside the block predicts and compares every event; this module
// only makes stimulus, reprograms between phases and gives the verdict.
// ----------------------------------------------------------------------------
module button_event_grammar_top_test;
	import bevg_pkg::*;

	localparam int CYCLE_LIMIT   = 1_500_000;
	localparam int SETTLE_CYCLES = 40;     // a tick scan covers all NUM_KEYS keys
	localparam int MAX_GAP       = 18;
	localparam int DRAIN_LIMIT   = 100_000;

	logic              clk;
	logic              arst_n;
	logic              psel;
	logic              penable;
	logic              pwrite;
	logic [ADDR_W-1:0] paddr;
	logic [DATA_W-1:0] pwdata;
	logic [DATA_W-1:0] prdata;
	logic              pready;

	int          fail_count;
	int          pending;
	bit          no_idle_run;   // when set, both sides run without gaps
	logic [15:0] shadow_down;   // rough view of which keys we left pressed

	bevg_in_if  key_if ();
	bevg_out_if evt_if ();

	button_event_grammar_top u_top (
		.clk     (clk),
		.arst_n  (arst_n),
		.key_in  (key_if),
		.evt_out (evt_if),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready)
	);

	bevg_event_checker u_checker (
		.clk        (clk),
		.arst_n     (arst_n),
		.key_mon    (key_if),
		.evt_mon    (evt_if),
		.psel       (psel),
		.penable    (penable),
		.pwrite     (pwrite),
		.pready     (pready),
		.paddr      (paddr),
		.pwdata     (pwdata),
		.fail_count (fail_count),
		.pending    (pending)
	);

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	// watchdog
	initial begin
		repeat (CYCLE_LIMIT) @(posedge clk);
		$display("[FAIL] regression broken");
		$finish;
	end

	// Event sink: after each transfer draw a stall length and hold ready low
	// for that many cycles. Sampling right after the edge sees pre-edge values.
	initial begin
		int stall;
		evt_if.ready <= 1'b0;
		stall = 0;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if (evt_if.valid && evt_if.ready)
				stall = no_idle_run ? 0 : $urandom_range(0, MAX_GAP);
			if (stall > 0) begin
				evt_if.ready <= 1'b0;
				stall--;
			end else begin
				evt_if.ready <= 1'b1;
			end
		end
	end

	// One key-channel transfer. Called at a clock edge; returns at the edge of
	// the transfer without touching valid, so back-to-back items keep it high.
	task automatic send_item(input logic act, input logic [3:0] key, input logic level);
		int gap;
		gap = no_idle_run ? 0 : $urandom_range(0, MAX_GAP);
		if (gap > 0) begin
			key_if.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		key_if.valid     <= 1'b1;
		key_if.action    <= act;
		key_if.key_index <= key;
		key_if.key_level <= level;
		do @(posedge clk); while (!(key_if.valid && key_if.ready));
	endtask

	// APB write: setup then access. psel stays up between back-to-back
	// writes so each signal sees one assignment per edge.
	task automatic write_reg(input logic [2:0] idx, input logic [31:0] value);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= {idx, 2'b00};
		pwdata  <= value;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
	endtask

	task automatic load_settings(input logic [15:0] long_t, input logic [15:0] rep_t,
		input logic [15:0] boot_t, input logic [3:0] first_key, input logic [3:0] last_key,
		input logic [15:0] absent);
		write_reg(REG_LONG_PRESS, {16'd0, long_t});
		write_reg(REG_REPEAT,     {16'd0, rep_t});
		write_reg(REG_STARTUP,    {16'd0, boot_t});
		write_reg(REG_SEL_FIRST,  {28'd0, first_key});
		write_reg(REG_SEL_LAST,   {28'd0, last_key});
		write_reg(REG_ABSENT,     {16'd0, absent});
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
	endtask

	// Quiesce: drop valid, wait for every outstanding event (checked on the
	// falling edge so the checker has already booked this edge), then give a
	// tick that produced nothing time to finish its scan.
	task automatic settle();
		key_if.valid <= 1'b0;
		do @(negedge clk); while (pending != 0);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// Mostly proper press/release alternation per key mixed with ticks, so
	// keys get held long enough for long and repeat; some repeated levels and
	// out-of-range keys as noise. Tick items carry random unused fields.
	task automatic run_random_phase(input int count);
		int   k;
		logic level;
		for (int i = 0; i < count; i++) begin
			if (i % 32 == 0)
				no_idle_run = ($urandom_range(0, 3) == 0);
			if ($urandom_range(0, 99) < 45) begin
				send_item(ACT_TICK, 4'($urandom_range(0, 15)), 1'($urandom_range(0, 1)));
			end else begin
				k = ($urandom_range(0, 9) == 0) ? $urandom_range(NUM_KEYS, 15)
					: $urandom_range(0, NUM_KEYS - 1);
				level = ($urandom_range(0, 4) == 0) ? 1'($urandom_range(0, 1))
					: ~shadow_down[k];
				shadow_down[k] = level;
				send_item(ACT_KEY, 4'(k), level);
			end
		end
	endtask

	initial begin
		int w;
		key_if.valid     <= 1'b0;
		key_if.action    <= ACT_KEY;
		key_if.key_index <= 4'd0;
		key_if.key_level <= 1'b0;
		psel             <= 1'b0;
		penable          <= 1'b0;
		pwrite           <= 1'b0;
		paddr            <= '0;
		pwdata           <= '0;
		arst_n           <= 1'b0;
		shadow_down = '0;
		no_idle_run = 1'b0;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// --- directed, reset settings (long 300, keys 2 and 3 absent) ---
		send_item(ACT_TICK, 4'd15, 1'b1);   // tick ignores key fields
		send_item(ACT_KEY,  4'd0,  1'b1);   // press
		send_item(ACT_KEY,  4'd0,  1'b1);   // press while held: silent
		send_item(ACT_KEY,  4'd0,  1'b0);   // short + release
		send_item(ACT_KEY,  4'd0,  1'b0);   // release while up: silent
		send_item(ACT_KEY,  4'd2,  1'b1);   // absent key
		send_item(ACT_KEY,  4'd12, 1'b1);   // beyond key count
		send_item(ACT_KEY,  4'd15, 1'b1);
		settle();

		// --- directed, fast timing: long after 2 ticks, repeat every tick,
		//     selector default kicks in at tick 6 ---
		load_settings(16'd2, 16'd1, 16'd6, 4'd7, 4'd11, 16'd12);
		send_item(ACT_KEY,  4'd1,  1'b1);
		send_item(ACT_TICK, 4'd0,  1'b0);
		send_item(ACT_TICK, 4'd0,  1'b0);   // long
		send_item(ACT_TICK, 4'd0,  1'b0);   // repeat
		send_item(ACT_TICK, 4'd0,  1'b0);   // repeat
		send_item(ACT_TICK, 4'd0,  1'b0);   // startup timeout: position 0, then repeat
		send_item(ACT_KEY,  4'd1,  1'b0);   // release only, long already sent
		send_item(ACT_KEY,  4'd11, 1'b1);   // position event before press
		send_item(ACT_KEY,  4'd10, 1'b1);
		send_item(ACT_KEY,  4'd10, 1'b1);   // held selector, position unchanged
		send_item(ACT_KEY,  4'd11, 1'b1);   // held selector moves position, no press
		send_item(ACT_TICK, 4'd4,  1'b0);
		send_item(ACT_TICK, 4'd9,  1'b1);   // two keys go long in one scan
		send_item(ACT_KEY,  4'd10, 1'b0);
		send_item(ACT_KEY,  4'd11, 1'b0);
		settle();

		// --- random phases; keys left held carry into the next settings ---
		load_settings(16'd1, 16'd1, 16'd0, 4'd0, 4'd15, 16'h0000);
		run_random_phase(90);
		settle();

		// every key absent, empty selector range (first above last)
		load_settings(16'hFFFF, 16'hFFFF, 16'hFFFF, 4'd15, 4'd0, 16'hFFFF);
		run_random_phase(30);
		settle();

		load_settings(16'd3, 16'd2, 16'($urandom_range(0, 65535)), 4'd3, 4'd9, 16'h0120);
		run_random_phase(90);
		settle();

		repeat (4) begin
			load_settings(16'($urandom_range(1, 10)), 16'($urandom_range(1, 6)),
				16'($urandom_range(0, 65535)), 4'($urandom_range(0, 15)),
				4'($urandom_range(0, 15)), 16'($urandom & $urandom));
			run_random_phase(75);
			settle();
		end

		// drain whatever is still owed, bounded, then allow a last scan
		key_if.valid <= 1'b0;
		for (w = 0; w < DRAIN_LIMIT && pending != 0; w++)
			@(negedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
		if (fail_count == 0 && pending == 0)
			$display("[ OK ] regression clean");
		else
			$display("[FAIL] regression broken");
		$finish;
	end

endmodule

// ===== button_event_grammar_top.f =====
src/bevg_pkg.sv
src/bevg_in_if.sv
src/bevg_out_if.sv
src/button_event_grammar_top.sv
dv/bevg_event_checker.sv
dv/button_event_grammar_top_test.sv
